>>> hdl/twgt_pkg.sv
// Shared types, constants and arithmetic helpers of the twiddle gain tuner.
package twgt_pkg;

  typedef logic        [16:0] cnt_t;
  typedef logic        [15:0] steps_t;
  typedef logic        [30:0] step_t;
  typedef logic        [30:0] tol_t;
  typedef logic signed [31:0] gain_t;
  typedef logic        [31:0] err_in_t;
  typedef logic        [47:0] err_sum_t;
  typedef logic        [1:0]  idx_t;
  typedef logic        [1:0]  phase_t;
  typedef logic        [2:0]  cfg_idx_t;
  typedef logic        [31:0] cfg_data_t;

  // Control from the twiddle decision to the step scaler.
  typedef struct packed {
    logic grow;   // 1: step * 1.1, 0: step * 0.9
  } scale_ctl_t;

  localparam int unsigned MAX_GAINS = 3;

  // Search phase codes.
  localparam phase_t PH_DONE  = 2'd0;
  localparam phase_t PH_PROBE = 2'd1;
  localparam phase_t PH_BACK  = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_SETTLE = 3'd0;
  localparam cfg_idx_t CFG_RECORD = 3'd1;
  localparam cfg_idx_t CFG_TOL    = 3'd2;
  localparam cfg_idx_t CFG_INIT_P = 3'd3;
  localparam cfg_idx_t CFG_INIT_I = 3'd4;
  localparam cfg_idx_t CFG_INIT_D = 3'd5;

  // Reset values.
  localparam steps_t   SETTLE_RST = 16'd100;
  localparam steps_t   RECORD_RST = 16'd500;
  localparam tol_t     TOL_RST    = 31'd655;
  localparam err_sum_t ERR_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam step_t    STEP_MAX   = 31'h7FFF_FFFF;

  // Initial step sizes 0.2, 0.003, 2.9 in Q16.16.
  localparam step_t STEP_RST [MAX_GAINS] = '{31'd13107, 31'd197, 31'd190054};

  // Reciprocal of ten for a 32-bit dividend: (x * RECIP10) >> RECIP10_SHIFT.
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int unsigned RECIP10_SHIFT = 35;

  // Clamp a 34-bit signed sum into the signed 32-bit gain range.
  function automatic gain_t sat_gain(input logic [33:0] v);
    gain_t r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = gain_t'(v[31:0]);
    end else if (v[33]) begin
      r = gain_t'(32'h8000_0000);
    end else begin
      r = gain_t'(32'h7FFF_FFFF);
    end
    return r;
  endfunction

endpackage

>>> hdl/twgt_if.sv
// Valid/ready channel interfaces for error samples and tuner results.
interface twgt_in_if;
  logic                valid;
  logic                ready;
  twgt_pkg::err_in_t   error_sample;

  modport source (output valid, output error_sample, input ready);
  modport sink   (input valid, input error_sample, output ready);
endinterface

interface twgt_out_if;
  logic             valid;
  logic             ready;
  logic             gains_updated;
  logic             tuning_done;
  twgt_pkg::gain_t  gain_p;
  twgt_pkg::gain_t  gain_i;
  twgt_pkg::gain_t  gain_d;

  modport source (output valid, output gains_updated, output tuning_done,
                  output gain_p, output gain_i, output gain_d, input ready);
  modport sink   (input valid, input gains_updated, input tuning_done,
                  input gain_p, input gain_i, input gain_d, output ready);
endinterface

>>> hdl/twiddle_gain_tuner.sv
// Top level of the twiddle coordinate descent PID gain tuner.
//
// Usage:
//   in_ch carries one signed Q16.16 controller error sample per control step.
//   out_ch returns one result per sample: gains_updated, tuning_done and the
//   three Q16.16 gains as they stand after that sample.
//   cfg_we/cfg_idx/cfg_wdata write settle_steps, record_steps, tolerance and
//   the three initial gains; an initial gain write also loads the live gain.
//   Write configuration only while the block is idle.
// Timing:
//   An accepted item's result is registered and valid in the next cycle.
//   Throughput is one item per cycle unless the result register stalls; the
//   trial bookkeeping, the one 32x32 reciprocal multiply of the step scaler
//   and the saturating gain adders all sit between state and result registers.
// Reset (rst_n low, synchronous): registers return to 100/500/0.01, gains 0,
//   step sizes 0.2/0.003/2.9, best error infinite, phase probe, gain index 0.
// Back-pressure: the result register holds while out_ch.ready is low; a new
//   item is accepted whenever the result register is empty or being drained.
module twiddle_gain_tuner #(
  parameter int unsigned NUM_GAINS = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  twgt_in_if.sink                in_ch,
  twgt_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  twgt_pkg::cfg_idx_t     cfg_idx,
  input  twgt_pkg::cfg_data_t    cfg_wdata
);

  localparam int unsigned NG = twgt_pkg::MAX_GAINS;

  // configuration
  twgt_pkg::steps_t   settle_r;
  twgt_pkg::steps_t   record_r;
  twgt_pkg::tol_t     tol_r;

  // tuning state
  twgt_pkg::cnt_t     cnt_r,   cnt_nxt;
  twgt_pkg::err_sum_t trial_r, trial_nxt;
  twgt_pkg::err_sum_t best_r,  best_nxt;
  twgt_pkg::gain_t    gain_r   [NG];
  twgt_pkg::gain_t    gain_nxt [NG];
  twgt_pkg::step_t    step_r   [NG];
  twgt_pkg::step_t    step_nxt [NG];
  twgt_pkg::phase_t   phase_r, phase_nxt;
  twgt_pkg::idx_t     idx_r,   idx_nxt;

  // result register
  logic               out_valid_r;
  logic               upd_r,   upd_nxt;
  logic               done_r;
  twgt_pkg::gain_t    out_gain_r [NG];

  logic               in_acc;

  // step / trial bookkeeping
  twgt_pkg::cnt_t     cnt_inc;
  twgt_pkg::cnt_t     trial_len;
  logic               trial_end;
  logic               add_en;
  twgt_pkg::err_sum_t sum_base;
  logic [48:0]        sum_wide;
  logic [31:0]        err_mag;

  // twiddle decision
  logic [32:0]        step_total;
  logic               below_tol;
  logic               act;
  logic               improve;
  logic               scale_en;
  logic               first_en;
  twgt_pkg::idx_t     idx_next;
  twgt_pkg::scale_ctl_t scale_ctl;
  twgt_pkg::step_t    scaled;
  twgt_pkg::step_t    step_mid [NG];
  twgt_pkg::gain_t    gain_mid [NG];
  logic [33:0]        add_a    [NG];
  logic [33:0]        add_b    [NG];

  // Accept whenever the result register can take the result.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Shared step scaler works on the current gain's step.
  assign scale_ctl.grow = improve;

  twgt_scale u_scale (
    .step_in  (step_r[idx_r]),
    .ctl      (scale_ctl),
    .step_out (scaled)
  );

  always_comb begin
    // Advance the step counter; the trial ends past settle + record.
    cnt_inc   = cnt_r + 17'd1;
    trial_len = {1'b0, settle_r} + {1'b0, record_r};
    trial_end = cnt_inc > trial_len;
    cnt_nxt   = trial_end ? '0 : cnt_inc;

    // Accumulate |error| in the record window, saturating at 48 bits.
    err_mag   = in_ch.error_sample[31] ? (~in_ch.error_sample + 32'd1)
                                       : in_ch.error_sample;
    add_en    = cnt_nxt >= {1'b0, settle_r};
    sum_base  = trial_end ? '0 : trial_r;
    sum_wide  = {1'b0, sum_base} + {17'd0, err_mag};
    if (!add_en) begin
      trial_nxt = sum_base;
    end else if (sum_wide[48]) begin
      trial_nxt = twgt_pkg::ERR_MAX;
    end else begin
      trial_nxt = sum_wide[47:0];
    end

    // Sum the active step sizes against the tolerance.
    step_total = '0;
    for (int k = 0; k < NG; k++) begin
      if (k < NUM_GAINS) begin
        step_total = step_total + {2'b00, step_r[k]};
      end
    end
    below_tol = step_total < {2'b00, tol_r};

    improve   = trial_r < best_r;
    act       = trial_end && (phase_r != twgt_pkg::PH_DONE) && !below_tol;
    upd_nxt   = act;
    idx_next  = (idx_r == twgt_pkg::idx_t'(NUM_GAINS - 1)) ? '0 : idx_r + 2'd1;

    phase_nxt = phase_r;
    best_nxt  = best_r;
    idx_nxt   = idx_r;
    scale_en  = 1'b0;
    first_en  = 1'b0;

    if (trial_end && (phase_r != twgt_pkg::PH_DONE) && below_tol) begin
      phase_nxt = twgt_pkg::PH_DONE;
    end else if (act) begin
      if (improve) begin
        best_nxt = trial_r;
      end
      case (phase_r)
        twgt_pkg::PH_PROBE: begin
          if (improve) begin
            scale_en = 1'b1;
            idx_nxt  = idx_next;
          end else begin
            // back off by twice the step
            first_en  = 1'b1;
            phase_nxt = twgt_pkg::PH_BACK;
          end
        end
        default: begin
          // backed-off trial: grow on success, restore and shrink on failure
          scale_en  = 1'b1;
          first_en  = !improve;
          idx_nxt   = idx_next;
          phase_nxt = twgt_pkg::PH_PROBE;
        end
      endcase
    end

    // Per-gain update: first touch at the current index, then the probe
    // step onto the next index (both can hit the same gain with one gain).
    for (int k = 0; k < NG; k++) begin
      step_mid[k] = (scale_en && (idx_r == twgt_pkg::idx_t'(k))) ? scaled : step_r[k];
      add_a[k]    = {{2{gain_r[k][31]}}, gain_r[k]};
      if (phase_r == twgt_pkg::PH_PROBE) begin
        add_b[k] = add_a[k] - {2'b00, step_r[k], 1'b0};
      end else begin
        add_b[k] = add_a[k] + {3'b000, step_r[k]};
      end
      gain_mid[k] = (first_en && (idx_r == twgt_pkg::idx_t'(k)))
                    ? twgt_pkg::sat_gain(add_b[k]) : gain_r[k];
      step_nxt[k] = step_mid[k];
      if (scale_en && (idx_next == twgt_pkg::idx_t'(k))) begin
        gain_nxt[k] = twgt_pkg::sat_gain({{2{gain_mid[k][31]}}, gain_mid[k]}
                                         + {3'b000, step_mid[k]});
      end else begin
        gain_nxt[k] = gain_mid[k];
      end
    end
  end

  // Configuration and tuning state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= twgt_pkg::SETTLE_RST;
      record_r <= twgt_pkg::RECORD_RST;
      tol_r    <= twgt_pkg::TOL_RST;
      cnt_r    <= '0;
      trial_r  <= '0;
      best_r   <= twgt_pkg::ERR_MAX;
      phase_r  <= twgt_pkg::PH_PROBE;
      idx_r    <= '0;
      for (int k = 0; k < NG; k++) begin
        gain_r[k] <= '0;
        step_r[k] <= twgt_pkg::STEP_RST[k];
      end
    end else begin
      if (in_acc) begin
        cnt_r   <= cnt_nxt;
        trial_r <= trial_nxt;
        best_r  <= best_nxt;
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        for (int k = 0; k < NG; k++) begin
          gain_r[k] <= gain_nxt[k];
          step_r[k] <= step_nxt[k];
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          twgt_pkg::CFG_SETTLE: settle_r <= cfg_wdata[15:0];
          twgt_pkg::CFG_RECORD: record_r <= cfg_wdata[15:0];
          twgt_pkg::CFG_TOL:    tol_r    <= cfg_wdata[30:0];
          twgt_pkg::CFG_INIT_P: gain_r[0] <= twgt_pkg::gain_t'(cfg_wdata);
          twgt_pkg::CFG_INIT_I: gain_r[1] <= twgt_pkg::gain_t'(cfg_wdata);
          twgt_pkg::CFG_INIT_D: gain_r[2] <= twgt_pkg::gain_t'(cfg_wdata);
          default: ;  // drop writes to unknown registers
        endcase
      end
    end
  end

  // Result register: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      upd_r  <= upd_nxt;
      done_r <= (phase_nxt == twgt_pkg::PH_DONE);
      for (int k = 0; k < NG; k++) begin
        out_gain_r[k] <= gain_nxt[k];
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.gains_updated = upd_r;
  assign out_ch.tuning_done   = done_r;
  assign out_ch.gain_p        = out_gain_r[0];
  assign out_ch.gain_i        = out_gain_r[1];
  assign out_ch.gain_d        = out_gain_r[2];

endmodule

>>> hdl/twgt_scale.sv
// Step size scaler: rounded multiply by 1.1 or 0.9 with saturation.
module twgt_scale (
  input  twgt_pkg::step_t      step_in,
  input  twgt_pkg::scale_ctl_t ctl,
  output twgt_pkg::step_t      step_out
);

  logic [31:0] dividend;
  logic [63:0] prod;
  logic [28:0] tenth;
  logic [31:0] grown;

  // (11s+5)/10 = s + (s+5)/10 ; (9s+5)/10 = s - (s+4)/10
  always_comb begin
    dividend = {1'b0, step_in} + (ctl.grow ? 32'd5 : 32'd4);
    prod     = 64'(dividend) * 64'(twgt_pkg::RECIP10);
    tenth    = prod[63:twgt_pkg::RECIP10_SHIFT];
    grown    = {1'b0, step_in} + {3'b000, tenth};
    if (ctl.grow) begin
      step_out = grown[31] ? twgt_pkg::STEP_MAX : grown[30:0];
    end else begin
      step_out = step_in - {2'b00, tenth};
    end
  end

endmodule

>>> hdl/twgt_checker.sv
// Port-level assertions for the twiddle gain tuner, bound to the top level.
module twgt_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            gains_updated,
  input logic            tuning_done,
  input twgt_pkg::gain_t gain_p
);

  // An accepted item shows its result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item produced no result");

  // Input stalls only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // A finished tuner never reports a gain change.
  a_done_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && tuning_done) |-> !gains_updated)
    else $error("gains updated after tuning finished");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(gain_p)
                                   && $stable(tuning_done)))
    else $error("stalled result changed");

endmodule

bind twiddle_gain_tuner twgt_checker u_twgt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .gains_updated (out_ch.gains_updated),
  .tuning_done   (out_ch.tuning_done),
  .gain_p        (out_ch.gain_p)
);
